@@ rtl/pdr_pkg.sv @@
// Shared types, constants and helper functions of the path prefix redaction stream.
package pdr_pkg;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOME_LENGTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOME_BYTES_0 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOME_BYTES_1 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOME_BYTES_2 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOME_BYTES_3 = 3'd4;
    localparam int HOME_LEN_W = 6;
    localparam int HOME_BYTES = 32;

    // Characters and UTF-8 lead byte test.
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] UTF8_MASK    = 8'hC0;
    localparam logic [7:0] UTF8_CONT    = 8'h80;

    // Replacement token.
    localparam int TOKEN_LEN = 13;
    localparam int TOK_IDX_W = 4;
    localparam logic [TOK_IDX_W-1:0] TOKEN_LAST_IDX = TOK_IDX_W'(TOKEN_LEN - 1);
    localparam logic [0:TOKEN_LEN-1][7:0] TOKEN_TEXT = "%USERPROFILE%";

    // Command queue between front and back. Depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic {
        CMD_BYTE,
        CMD_TOKEN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       last;
    } pdr_cmd_t;

    typedef enum logic {
        FE_RUN,
        FE_FLUSH
    } fe_state_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]}) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [7:0] token_byte(input logic [TOK_IDX_W-1:0] idx);
        logic [7:0] r;
        r = 8'h00;
        if (int'(idx) < TOKEN_LEN) begin
            r = TOKEN_TEXT[idx];
        end
        return r;
    endfunction

endpackage

@@ rtl/pdr_front.sv @@
// Front part: configuration registers, match window, and command generation.
module pdr_front
    import pdr_pkg::*;
#(
    parameter int WIN = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_byte,
    input  logic                  s_last,
    input  logic                  q_full,
    output logic                  q_push,
    output pdr_cmd_t              q_cmd
);

    localparam int FW = $clog2(WIN + 1);

    logic [HOME_LEN_W-1:0]         len_reg;
    logic [HOME_BYTES-1:0][7:0]    path_reg;
    logic [7:0]                    win_reg  [WIN];
    logic [7:0]                    win_next [WIN];
    logic [7:0]                    cand     [WIN];
    logic [FW-1:0]                 fill_reg, fill_next, fill_inc, n_len, n_less;
    fe_state_t                     state_reg, state_next;
    logic [WIN-1:0]                ok_plain, ok_slash;
    logic                          disabled, match, cfg_clear;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            path_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_HOME_LENGTH:  len_reg        <= cfg_wdata[HOME_LEN_W-1:0];
                CFG_HOME_BYTES_0: path_reg[7:0]   <= cfg_wdata;
                CFG_HOME_BYTES_1: path_reg[15:8]  <= cfg_wdata;
                CFG_HOME_BYTES_2: path_reg[23:16] <= cfg_wdata;
                CFG_HOME_BYTES_3: path_reg[31:24] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg_clear = cfg_wr_en && (cfg_addr == CFG_HOME_LENGTH ||
                                     cfg_addr == CFG_HOME_BYTES_0 ||
                                     cfg_addr == CFG_HOME_BYTES_1 ||
                                     cfg_addr == CFG_HOME_BYTES_2 ||
                                     cfg_addr == CFG_HOME_BYTES_3);

    always_comb begin
        if (int'(len_reg) > WIN) begin
            n_len = FW'(WIN);
        end else begin
            n_len = FW'(len_reg);
        end
    end

    assign n_less   = n_len - FW'(1);
    assign disabled = (n_len == '0) || (n_len == FW'(1) && path_reg[0] == CH_SLASH);
    assign fill_inc = fill_reg + FW'(1);

    // The new byte lands at the fill position; the window is then compared as a whole,
    // once against the path and once against the path with backslashes as slashes.
    always_comb begin
        for (int k = 0; k < WIN; k++) begin
            cand[k]     = (fill_reg == FW'(k)) ? s_byte : win_reg[k];
            ok_plain[k] = (FW'(k) >= n_len) ||
                          (fold_case(cand[k]) == fold_case(path_reg[k]));
            ok_slash[k] = (FW'(k) >= n_len) ||
                          (fold_case(cand[k]) == fold_case(
                              (path_reg[k] == CH_BACKSLASH) ? CH_SLASH : path_reg[k]));
        end
    end

    assign match = ((cand[0] & UTF8_MASK) != UTF8_CONT) && ((&ok_plain) || (&ok_slash));

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        win_next   = win_reg;
        q_push     = 1'b0;
        q_cmd      = '{kind: CMD_BYTE, data: win_reg[0], last: 1'b0};
        s_ready    = (state_reg == FE_RUN) && !q_full;
        case (state_reg)
            FE_RUN: begin
                if (s_valid && s_ready) begin
                    if (disabled) begin
                        q_push    = 1'b1;
                        q_cmd     = '{kind: CMD_BYTE, data: s_byte, last: s_last};
                        fill_next = '0;
                    end else if (fill_inc == n_len) begin
                        q_push = 1'b1;
                        if (match) begin
                            q_cmd     = '{kind: CMD_TOKEN, data: s_byte, last: s_last};
                            fill_next = '0;
                        end else begin
                            q_cmd = '{kind: CMD_BYTE, data: cand[0],
                                      last: s_last && (n_less == '0)};
                            for (int k = 0; k < WIN - 1; k++) begin
                                win_next[k] = cand[k+1];
                            end
                            fill_next = n_less;
                            if (s_last && n_less != '0) begin
                                state_next = FE_FLUSH;
                            end
                        end
                    end else begin
                        win_next  = cand;
                        fill_next = fill_inc;
                        if (s_last) begin
                            state_next = FE_FLUSH;
                        end
                    end
                end
            end
            FE_FLUSH: begin
                // Drain what is left of the window, one byte per cycle while the queue is not full, oldest first.
                if (!q_full) begin
                    q_push = 1'b1;
                    q_cmd  = '{kind: CMD_BYTE, data: win_reg[0],
                               last: fill_reg <= FW'(1)};
                    for (int k = 0; k < WIN - 1; k++) begin
                        win_next[k] = win_reg[k+1];
                    end
                    if (fill_reg <= FW'(1)) begin
                        fill_next  = '0;
                        state_next = FE_RUN;
                    end else begin
                        fill_next = fill_reg - FW'(1);
                    end
                end
            end
            default: state_next = FE_RUN;
        endcase
        if (cfg_clear) begin
            fill_next  = '0;
            state_next = FE_RUN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FE_RUN;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule

@@ rtl/pdr_queue.sv @@
// Short command queue that decouples the front part from the back part.
module pdr_queue
    import pdr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  pdr_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output pdr_cmd_t head,
    output logic     not_empty
);

    localparam int QP_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    pdr_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QC_W-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == QC_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QC_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QP_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/pdr_back.sv @@
// Back part: expands commands into output bytes behind an output register.
module pdr_back
    import pdr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pdr_cmd_t   head,
    input  logic       not_empty,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_byte,
    output logic       m_last
);

    logic                 valid_reg, valid_next;
    logic [7:0]           data_reg, data_next;
    logic                 last_reg, last_next;
    logic [TOK_IDX_W-1:0] tok_reg, tok_next;
    logic                 load;

    assign load    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_byte  = data_reg;
    assign m_last  = last_reg;

    always_comb begin
        valid_next = valid_reg && !m_ready;
        data_next  = data_reg;
        last_next  = last_reg;
        tok_next   = tok_reg;
        pop        = 1'b0;
        if (load && not_empty) begin
            valid_next = 1'b1;
            case (head.kind)
                CMD_BYTE: begin
                    data_next = head.data;
                    last_next = head.last;
                    pop       = 1'b1;
                end
                CMD_TOKEN: begin
                    // A token command stays at the head until all its bytes are out.
                    data_next = token_byte(tok_reg);
                    last_next = head.last && (tok_reg == TOKEN_LAST_IDX);
                    if (tok_reg == TOKEN_LAST_IDX) begin
                        pop      = 1'b1;
                        tok_next = '0;
                    end else begin
                        tok_next = tok_reg + TOK_IDX_W'(1);
                    end
                end
                default: pop = 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

endmodule

@@ rtl/path_prefix_redaction_stream_core.sv @@
// Top level of the path prefix redaction stream: front, command queue and back.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------
//  s_axis   | in        | tvalid / tready       | tdata = text_byte, tlast = text_last
//  m_axis   | out       | tvalid / tready       | tdata = out_byte,  tlast = out_last
//  cfg      | in        | cfg_wr_en             | cfg_addr = register, cfg_wdata
//
// One input byte is taken per cycle while the queue has room, and one output byte leaves
// per cycle while m_axis_tready is high. A match pushes one token command, which the back
// part plays out as 13 bytes; the four-entry command queue absorbs that until it fills, and
// then s_axis_tready drops. After a byte marked last, the front drains the window one byte
// per cycle while the queue has room (up to the path length minus one), input held off.
// A byte waits in the window (not when replacement is off), then goes through the queue.
// Reset is synchronous and leaves the block empty and ready;
// any write to a defined register empties the window.
module path_prefix_redaction_stream_core
    import pdr_pkg::*;
#(
    parameter int PATTERN_MAX = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] text_byte
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] out_byte
    output logic                  m_axis_tlast
);

    localparam int WIN = (PATTERN_MAX < HOME_BYTES) ? PATTERN_MAX : HOME_BYTES;

    pdr_cmd_t push_cmd, head;
    logic     push, full, pop, not_empty;

    pdr_front #(
        .WIN(WIN)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_byte    (s_axis_tdata),
        .s_last    (s_axis_tlast),
        .q_full    (full),
        .q_push    (push),
        .q_cmd     (push_cmd)
    );

    pdr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty)
    );

    pdr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .not_empty (not_empty),
        .pop       (pop),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_byte    (m_axis_tdata),
        .m_last    (m_axis_tlast)
    );

endmodule

@@ rtl/pdr_checker.sv @@
// Port-level checks of the path prefix redaction stream, bound to the top level.
module pdr_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [7:0]            m_axis_tdata,
    input logic                  m_axis_tlast
);

    // A stalled output transfer keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
    else $error("output valid after reset");

    // When the input is held off and nothing is on the output, work is pending in the
    // queue or the window drain, so the property requires output data to show up.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready && !m_axis_tvalid |-> ##2 m_axis_tvalid)
    else $error("input stalled with no output progress");

endmodule

bind path_prefix_redaction_stream_core pdr_checker u_pdr_checker (.*);
